[rtl/core/mer_pkg.sv]
package mer_pkg;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  localparam int unsigned PIX_IDX_W = 2;
  localparam logic [PIX_IDX_W-1:0] PIX_LAST = 2'd3;

  typedef struct packed {
    logic                 load;
    logic                 init_dy;
    logic                 init_d;
    logic                 upd_xy;
    logic                 upd_d;
    logic                 tr_sq;
    logic                 tr_mul;
    logic                 tr_fin;
    logic                 emit;
    logic [PIX_IDX_W-1:0] pix_idx;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic need_trans;
    logic finished;
  } status_t;

endpackage

[rtl/core/mer_ctrl.sv]
module mer_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_mode,
  output logic              in_stall,
  input  mer_pkg::status_t  sts,
  output mer_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_READY,
    S_INIT_DY,
    S_INIT_D,
    S_UPD_D,
    S_TR_SQ,
    S_TR_MUL,
    S_TR_FIN,
    S_EMIT
  } state_t;

  state_t                        state;
  logic [mer_pkg::PIX_IDX_W-1:0] pix_cnt;
  logic                          active;
  logic                          stepping;
  logic                          accept;

  assign in_stall = (state != S_READY);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd         = '0;
    cmd.pix_idx = pix_cnt;
    cmd.load    = accept && (in_mode == mer_pkg::MODE_START);
    cmd.upd_xy  = accept && (in_mode == mer_pkg::MODE_STEP) && active;
    unique case (state)
      S_INIT_DY: cmd.init_dy = 1'b1;
      S_INIT_D:  cmd.init_d  = 1'b1;
      S_UPD_D:   cmd.upd_d   = 1'b1;
      S_TR_SQ:   cmd.tr_sq   = 1'b1;
      S_TR_MUL:  cmd.tr_mul  = 1'b1;
      S_TR_FIN:  cmd.tr_fin  = 1'b1;
      S_EMIT:    cmd.emit    = sts.out_free;
      default:   cmd.emit    = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_READY;
      pix_cnt  <= '0;
      active   <= 1'b0;
      stepping <= 1'b0;
    end else begin
      unique case (state)
        S_READY: begin
          if (cmd.load) begin
            state    <= S_INIT_DY;
            active   <= 1'b1;
            stepping <= 1'b0;
          end else if (cmd.upd_xy) begin
            state    <= S_UPD_D;
            stepping <= 1'b1;
          end
        end
        S_INIT_DY: state <= S_INIT_D;
        S_INIT_D: begin
          state <= sts.need_trans ? S_TR_SQ : S_READY;
        end
        S_UPD_D: begin
          state   <= sts.need_trans ? S_TR_SQ : S_EMIT;
          pix_cnt <= '0;
        end
        S_TR_SQ:  state <= S_TR_MUL;
        S_TR_MUL: state <= S_TR_FIN;
        S_TR_FIN: begin
          state   <= stepping ? S_EMIT : S_READY;
          pix_cnt <= '0;
        end
        S_EMIT: begin
          if (cmd.emit) begin
            pix_cnt <= pix_cnt + 1'b1;
            if (pix_cnt == mer_pkg::PIX_LAST) begin
              state <= S_READY;
              if (sts.finished) begin
                active <= 1'b0;
              end
            end
          end
        end
        default: state <= S_READY;
      endcase
    end
  end

  a_emit_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("Pixel issued while the output register is still occupied.");

  a_done_ends_on_last_pixel: assert property (@(posedge clk) disable iff (rst)
    $fell(active) |-> $past(cmd.emit && (cmd.pix_idx == mer_pkg::PIX_LAST) && sts.finished))
    else $error("Drawing ended without issuing the last pixel of the final step.");

  a_start_blocks_next: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !cmd.emit && !cmd.upd_xy && !cmd.load)
    else $error("Start setup overlapped with another transfer.");

endmodule

[rtl/core/mer_datapath.sv]
module mer_datapath #(
  parameter int unsigned RADIUS_BITS = 11,
  parameter int unsigned COORD_BITS  = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mer_pkg::cmd_t                 cmd,
  output mer_pkg::status_t              sts,
  input  logic [RADIUS_BITS-1:0]        radius_x,
  input  logic [RADIUS_BITS-1:0]        radius_y,
  input  logic [RADIUS_BITS-1:0]        centre_x,
  input  logic [RADIUS_BITS-1:0]        centre_y,
  input  logic                          cfg_write,
  input  logic [23:0]                   cfg_color,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  pixel_x,
  output logic signed [COORD_BITS-1:0]  pixel_y,
  output logic [23:0]                   pixel_rgb,
  output logic                          last_of_step,
  output logic                          ellipse_done
);

  localparam int unsigned RB   = RADIUS_BITS;
  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned SQW  = 2 * RB;
  localparam int unsigned DYW  = 3 * RB;
  localparam int unsigned PW   = RB + 2;
  localparam int unsigned AW   = PW + 1;
  localparam int unsigned SAW  = 2 * AW;
  localparam int unsigned PRW  = SQW + SAW;
  localparam int unsigned DWF  = 4 * RB + 8;
  localparam int unsigned DW   = (DWF > 64) ? 64 : DWF;

  logic [23:0]            color;
  logic [RB-1:0]          rx, ry, xc, yc;
  logic [SQW-1:0]         rx2, ry2;
  logic signed [PW-1:0]   px, py, ex, ey;
  logic [DW-1:0]          dx, dy, d;
  logic                   region2;
  logic                   incx, decy;
  logic [SAW-1:0]         aa;
  logic signed [SAW-1:0]  bb;
  logic [2*SQW-1:0]       rr;
  logic [PRW-1:0]         p1, p2;

  logic [DYW-1:0]         rx2ry;
  logic [AW-1:0]          a_val;
  logic signed [AW-1:0]   b_val;
  logic                   dneg, dpos;
  logic                   incx_now, decy_now;
  logic [CB-1:0]          ex_c, ey_c, x_ofs, y_ofs;

  assign rx2ry    = DYW'(rx2) * DYW'(ry);
  assign a_val    = {px[PW-1:0], 1'b1};
  assign b_val    = AW'(py) - AW'(1);
  assign dneg     = d[DW-1];
  assign dpos     = !d[DW-1] && (d != '0);
  assign incx_now = !region2 || !dpos;
  assign decy_now = region2 || !dneg;

  assign ex_c  = CB'(ex);
  assign ey_c  = CB'(ey);
  assign x_ofs = cmd.pix_idx[0] ? -ex_c : ex_c;
  assign y_ofs = cmd.pix_idx[1] ? -ey_c : ey_c;

  assign sts.out_free   = !out_valid || !out_stall;
  assign sts.need_trans = !region2 && !($signed(dx) < $signed(dy));
  assign sts.finished   = region2 && py[PW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      color   <= '0;
      region2 <= 1'b0;
    end else begin
      if (cfg_write) begin
        color <= cfg_color;
      end
      if (cmd.load) begin
        region2 <= 1'b0;
      end else if (cmd.tr_fin) begin
        region2 <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rx  <= radius_x;
      ry  <= radius_y;
      xc  <= centre_x;
      yc  <= centre_y;
      rx2 <= SQW'(radius_x) * SQW'(radius_x);
      ry2 <= SQW'(radius_y) * SQW'(radius_y);
      px  <= '0;
      py  <= PW'(radius_y);
      dx  <= '0;
    end
    if (cmd.init_dy) begin
      dy <= DW'(rx2ry) << 1;
    end
    if (cmd.init_d) begin
      d <= (DW'(ry2) << 2) - (dy << 1) + DW'(rx2);
    end
    if (cmd.upd_xy) begin
      ex   <= px;
      ey   <= py;
      incx <= incx_now;
      decy <= decy_now;
      if (incx_now) begin
        px <= px + PW'(1);
        dx <= dx + (DW'(ry2) << 1);
      end
      if (decy_now) begin
        py <= py - PW'(1);
        dy <= dy - (DW'(rx2) << 1);
      end
    end
    if (cmd.upd_d) begin
      d <= d + (incx ? (dx << 2) : '0) - (decy ? (dy << 2) : '0)
             + (region2 ? (DW'(rx2) << 2) : (DW'(ry2) << 2));
    end
    if (cmd.tr_sq) begin
      aa <= SAW'(a_val) * SAW'(a_val);
      bb <= SAW'(b_val) * SAW'(b_val);
      rr <= (2 * SQW)'(rx2) * (2 * SQW)'(ry2);
    end
    if (cmd.tr_mul) begin
      p1 <= PRW'(ry2) * PRW'(aa);
      p2 <= PRW'(rx2) * PRW'($unsigned(bb));
    end
    if (cmd.tr_fin) begin
      d <= DW'(p1) + (DW'(p2) << 2) - (DW'(rr) << 2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_x      <= CB'(xc) + x_ofs;
      pixel_y      <= CB'(yc) + y_ofs;
      pixel_rgb    <= color;
      last_of_step <= (cmd.pix_idx == mer_pkg::PIX_LAST);
      ellipse_done <= sts.finished;
    end
  end

  a_region_clears_on_start: assert property (@(posedge clk) disable iff (rst)
    $fell(region2) |-> $past(cmd.load))
    else $error("Region two left without a new start.");

  a_geometry_held: assert property (@(posedge clk) disable iff (rst)
    !$stable(rx) |-> $past(cmd.load))
    else $error("Saved radius changed outside a start.");

  a_last_pixel_marked: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && (cmd.pix_idx == mer_pkg::PIX_LAST)) |=> out_valid && last_of_step)
    else $error("Fourth pixel of a step was not marked as last.");

endmodule

[rtl/core/midpoint_ellipse_rasterizer.sv]
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  mode, radius_x, radius_y, centre_x, centre_y
// output    out        out_valid/out_stall  pixel_x, pixel_y, pixel_rgb, last_of_step,
//                                           ellipse_done
// config    in         cfg_valid/cfg_ready  pixel_color
//
// A step is the transfer, one decision update, and four pixel transfers.
// Leaving region one adds the squaring and multiply chain (S_TR_SQ, S_TR_MUL, S_TR_FIN).
// A start passes through S_INIT_DY and S_INIT_D, plus that chain when it lands directly in region two.
// Reset is synchronous and clears the controller, the region flag and the color.
// A stalled output holds the controller in its pixel state; in_stall stays high meanwhile.
module midpoint_ellipse_rasterizer #(
  parameter int unsigned RADIUS_BITS = 11,
  parameter int unsigned COORD_BITS  = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [RADIUS_BITS-1:0]        radius_x,
  input  logic [RADIUS_BITS-1:0]        radius_y,
  input  logic [RADIUS_BITS-1:0]        centre_x,
  input  logic [RADIUS_BITS-1:0]        centre_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  pixel_x,
  output logic signed [COORD_BITS-1:0]  pixel_y,
  output logic [23:0]                   pixel_rgb,
  output logic                          last_of_step,
  output logic                          ellipse_done,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [23:0]                   pixel_color
);

  mer_pkg::cmd_t    cmd;
  mer_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  mer_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_mode  (mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mer_datapath #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .radius_x     (radius_x),
    .radius_y     (radius_y),
    .centre_x     (centre_x),
    .centre_y     (centre_y),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_color    (pixel_color),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_rgb    (pixel_rgb),
    .last_of_step (last_of_step),
    .ellipse_done (ellipse_done)
  );

endmodule

[dv/tb_midpoint_ellipse_rasterizer.sv]
module tb_midpoint_ellipse_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAD_W = 11;
  localparam int COORD_W = 13;
  localparam int RAD_MAX = (1 << RAD_W) - 1;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int NO_LIMIT = 1 << 30;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [23:0]        rgb;
    logic               last;
    logic               done;
  } pixel_t;

  class ellipse_scoreboard;
    logic [23:0] color;
    int          pt_x;
    int          pt_y;
    logic [63:0] dx;
    logic [63:0] dy;
    logic [63:0] decision;
    bit          region_two;
    bit          active;
    logic [63:0] rx;
    logic [63:0] ry;
    int          cx;
    int          cy;
    pixel_t      want_q[$];
    int          errors;
    int          checked;
    int          finished;

    function bit settle();
      logic [63:0] rx2;
      logic [63:0] ry2;
      logic [63:0] a;
      longint      b;
      logic [63:0] bb;
      if (!region_two && !($signed(dx) < $signed(dy))) begin
        rx2 = rx * rx;
        ry2 = ry * ry;
        a = 64'd2 * pt_x + 64'd1;
        b = longint'(pt_y) - 1;
        bb = b * b;
        decision = ry2 * a * a + 64'd4 * rx2 * bb - 64'd4 * rx2 * ry2;
        region_two = 1'b1;
      end
      return !(region_two && pt_y < 0);
    endfunction

    function void note_input(logic m, logic [RAD_W-1:0] in_rx, logic [RAD_W-1:0] in_ry,
                             logic [RAD_W-1:0] in_cx, logic [RAD_W-1:0] in_cy);
      logic [63:0] rx2;
      logic [63:0] ry2;
      int          xs[4];
      int          ys[4];
      bit          done;
      pixel_t      px;
      if (m == mer_pkg::MODE_START) begin
        rx = 64'(in_rx);
        ry = 64'(in_ry);
        cx = int'(in_cx);
        cy = int'(in_cy);
        rx2 = rx * rx;
        ry2 = ry * ry;
        pt_x = 0;
        pt_y = int'(ry);
        dx = '0;
        dy = 64'd2 * rx2 * ry;
        decision = 64'd4 * ry2 - 64'd4 * rx2 * ry + rx2;
        region_two = 1'b0;
        active = 1'b1;
        void'(settle());
        return;
      end
      if (!active) return;
      rx2 = rx * rx;
      ry2 = ry * ry;
      xs[0] = cx + pt_x;
      ys[0] = cy + pt_y;
      xs[1] = cx - pt_x;
      ys[1] = ys[0];
      xs[2] = xs[0];
      ys[2] = cy - pt_y;
      xs[3] = xs[1];
      ys[3] = ys[2];
      if (!region_two) begin
        pt_x++;
        dx += 64'd2 * ry2;
        if ($signed(decision) < 0) begin
          decision += 64'd4 * dx + 64'd4 * ry2;
        end else begin
          pt_y--;
          dy -= 64'd2 * rx2;
          decision += 64'd4 * dx - 64'd4 * dy + 64'd4 * ry2;
        end
      end else begin
        pt_y--;
        dy -= 64'd2 * rx2;
        if ($signed(decision) > 0) begin
          decision += 64'd4 * rx2 - 64'd4 * dy;
        end else begin
          pt_x++;
          dx += 64'd2 * ry2;
          decision += 64'd4 * dx - 64'd4 * dy + 64'd4 * rx2;
        end
      end
      done = !settle();
      if (done) begin
        active = 1'b0;
        finished++;
      end
      for (int k = 0; k < 4; k++) begin
        px.x = xs[k][COORD_W-1:0];
        px.y = ys[k][COORD_W-1:0];
        px.rgb = color;
        px.last = (k == mer_pkg::PIX_LAST);
        px.done = done;
        want_q.push_back(px);
      end
    endfunction

    function void check_result(pixel_t got);
      pixel_t want;
      if (want_q.size() == 0) begin
        errors++;
        $error("Pixel transfer with none expected: x=%0d y=%0d",
               $signed(got.x), $signed(got.y));
        return;
      end
      want = want_q.pop_front();
      checked++;
      if (got.x !== want.x) begin
        errors++;
        $error("pixel_x: expected %0d, got %0d", $signed(want.x), $signed(got.x));
      end
      if (got.y !== want.y) begin
        errors++;
        $error("pixel_y: expected %0d, got %0d", $signed(want.y), $signed(got.y));
      end
      if (got.rgb !== want.rgb) begin
        errors++;
        $error("pixel_rgb: expected %06h, got %06h", want.rgb, got.rgb);
      end
      if (got.last !== want.last) begin
        errors++;
        $error("last_of_step: expected %0b, got %0b", want.last, got.last);
      end
      if (got.done !== want.done) begin
        errors++;
        $error("ellipse_done: expected %0b, got %0b", want.done, got.done);
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic                      mode;
  logic [RAD_W-1:0]          radius_x;
  logic [RAD_W-1:0]          radius_y;
  logic [RAD_W-1:0]          centre_x;
  logic [RAD_W-1:0]          centre_y;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [COORD_W-1:0] pixel_x;
  logic signed [COORD_W-1:0] pixel_y;
  logic [23:0]               pixel_rgb;
  logic                      last_of_step;
  logic                      ellipse_done;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [23:0]               pixel_color;

  ellipse_scoreboard sb = new();
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int transfers = 0;
  int starts = 0;
  int colors = 0;
  int idle_cycles = 0;

  midpoint_ellipse_rasterizer #(
    .RADIUS_BITS(RAD_W),
    .COORD_BITS (COORD_W)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .radius_x    (radius_x),
    .radius_y    (radius_y),
    .centre_x    (centre_x),
    .centre_y    (centre_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_rgb   (pixel_rgb),
    .last_of_step(last_of_step),
    .ellipse_done(ellipse_done),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .pixel_color (pixel_color)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(pixel_t'{pixel_x, pixel_y, pixel_rgb, last_of_step, ellipse_done});
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // The receiver stalls at random unless calm is set, except for one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 14);
      end
    end
  end

  task automatic send_item(logic m, logic [RAD_W-1:0] rx, logic [RAD_W-1:0] ry,
                           logic [RAD_W-1:0] cx, logic [RAD_W-1:0] cy);
    bit taken;
    while (!calm && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    radius_x <= rx;
    radius_y <= ry;
    centre_x <= cx;
    centre_y <= cy;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
    end
    sb.note_input(m, rx, ry, cx, cy);
    transfers++;
    if (m == mer_pkg::MODE_START) starts++;
    @(negedge clk);
  endtask

  task automatic send_step();
    send_item(mer_pkg::MODE_STEP, RAD_W'($urandom_range(0, RAD_MAX)),
              RAD_W'($urandom_range(0, RAD_MAX)), RAD_W'($urandom_range(0, RAD_MAX)),
              RAD_W'($urandom_range(0, RAD_MAX)));
  endtask

  task automatic draw(int rx, int ry, int cx, int cy, int max_steps, inout int counted);
    int n;
    n = 0;
    send_item(mer_pkg::MODE_START, RAD_W'(rx), RAD_W'(ry), RAD_W'(cx), RAD_W'(cy));
    counted++;
    while (sb.active && n < max_steps) begin
      send_step();
      n++;
      counted++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_color(logic [23:0] value);
    bit taken;
    cfg_valid <= 1'b1;
    pixel_color <= value;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = cfg_ready;
    end
    sb.color = value;
    colors++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int target);
    int counted;
    int r;
    int rx;
    int ry;
    int max_steps;
    counted = 0;
    while (counted < target) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        rx = $urandom_range(0, RAD_MAX);
        ry = $urandom_range(0, RAD_MAX);
        max_steps = $urandom_range(1, 4);
      end else if (r < 20) begin
        rx = $urandom_range(0, 6);
        ry = $urandom_range(0, 6);
        max_steps = $urandom_range(0, 3);
      end else begin
        rx = $urandom_range(0, 6);
        ry = $urandom_range(0, 6);
        max_steps = NO_LIMIT;
      end
      draw(rx, ry, $urandom_range(0, RAD_MAX), $urandom_range(0, RAD_MAX), max_steps, counted);
      if (!sb.active && $urandom_range(0, 99) < 15) send_step();
    end
  endtask

  initial begin
    int counted;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = mer_pkg::MODE_START;
    radius_x = '0;
    radius_y = '0;
    centre_x = '0;
    centre_y = '0;
    cfg_valid = 1'b0;
    pixel_color = '0;
    counted = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_color(24'($urandom_range(0, 24'hFFFFFF)));
    send_step();
    draw(0, 0, 0, 0, NO_LIMIT, counted);
    send_step();
    draw(0, 2, RAD_MAX, RAD_MAX, NO_LIMIT, counted);
    draw(3, 0, 5, 5, NO_LIMIT, counted);
    draw(RAD_MAX, RAD_MAX, 0, 0, 2, counted);
    draw(RAD_MAX, 1, RAD_MAX, RAD_MAX, 2, counted);
    draw(1, RAD_MAX, 1024, 1024, 2, counted);
    draw(3, 2, 100, 50, NO_LIMIT, counted);
    drain();

    write_color(24'hFFFFFF);
    hold_req = 1'b1;
    run_random(32);
    drain();

    write_color(24'h000000);
    calm = 1'b1;
    run_random(16);
    calm = 1'b0;
    run_random(16);
    drain();

    write_color(24'($urandom_range(0, 24'hFFFFFF)));
    run_random(8);
    drain();

    $display("Run covered %0d input transfers (%0d starts), %0d pixels checked,",
             transfers, starts, sb.checked);
    $display("%0d ellipses drawn to the end, %0d color writes.", sb.finished, colors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/mer_pkg.sv
rtl/core/mer_ctrl.sv
rtl/core/mer_datapath.sv
rtl/core/midpoint_ellipse_rasterizer.sv
dv/tb_midpoint_ellipse_rasterizer.sv
